/* rtl/core/lcdv_pkg.sv */
package lcdv_pkg;

  localparam int BANK_BYTES = 384;
  localparam int VRAM_DEPTH = 2 * BANK_BYTES;
  localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
  localparam int RAM_AW     = 9;

  localparam logic [1:0] OP_CTRL  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;

  localparam logic [3:0] CMD_VREAD    = 4'h1;
  localparam logic [3:0] CMD_VWRITE   = 4'h2;
  localparam logic [3:0] CMD_CHAR     = 4'h3;
  localparam logic [3:0] CMD_DISP     = 4'h4;
  localparam logic [3:0] CMD_CURPAT   = 4'h6;
  localparam logic [3:0] CMD_CURCHR   = 4'h7;
  localparam logic [3:0] CMD_MODE     = 4'h8;
  localparam logic [3:0] CMD_CURMODE  = 4'h9;
  localparam logic [3:0] CMD_GLYPH    = 4'hb;
  localparam logic [3:0] CMD_CONTRAST = 4'hc;
  localparam logic [3:0] CMD_IRQ      = 4'hd;
  localparam logic [3:0] CMD_CURPOS   = 4'he;

  localparam logic [2:0] ROP_NOTA_AND = 3'd0;
  localparam logic [2:0] ROP_XOR      = 3'd1;
  localparam logic [2:0] ROP_ANDN     = 3'd3;
  localparam logic [2:0] ROP_COPY     = 3'd4;
  localparam logic [2:0] ROP_OR       = 3'd5;
  localparam logic [2:0] ROP_KEEP     = 3'd7;

  localparam logic [1:0] PIDX_LAST = 2'd3;

  typedef enum logic [1:0] {
    BUS_KEEP = 2'd0,
    BUS_ONES = 2'd1,
    BUS_SWAP = 2'd2
  } bus_act_t;

  typedef struct packed {
    logic               valid;
    bus_act_t           act;
    logic               wr;
    logic [2:0]         rop;
    logic [7:0]         data;
    logic [VRAM_AW-1:0] addr;
  } lcdv_acc_t;

  function automatic logic [7:0] raster_op(input logic [2:0] rop, input logic [7:0] old,
                                           input logic [7:0] val);
    logic [7:0] res;
    case (rop)
      ROP_NOTA_AND: res = ~old & val;
      ROP_XOR:      res = old ^ val;
      ROP_ANDN:     res = old & ~val;
      ROP_COPY:     res = val;
      ROP_OR:       res = old | val;
      ROP_KEEP:     res = old;
      default:      res = 8'h00;
    endcase
    return res;
  endfunction

  function automatic logic [RAM_AW-1:0] column_code(input logic [7:0] d);
    logic [5:0] x;
    logic [5:0] m;
    x = d[6:1];
    m = (x >= 6'd48) ? (x - 6'd48) : x;
    return RAM_AW'(m) + (d[7] ? RAM_AW'(48) : RAM_AW'(0));
  endfunction

endpackage

/* rtl/core/lcdv_cmd.sv */
module lcdv_cmd
  import lcdv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [1:0]       op_i,
  input  logic [7:0]       data_i,
  output logic [VRAM_AW-1:0] rd_addr_o,
  output lcdv_acc_t        acc_o
);

  logic [7:0]        ctl_r, ctl_nxt;
  logic [1:0]        pidx_r, pidx_nxt;
  logic [7:0]        pb0_r, pb0_nxt;
  logic              bank_r, bank_nxt;
  logic [RAM_AW-1:0] ram_r, ram_nxt;
  logic [7:0]        tc_r, tc_nxt;
  lcdv_acc_t         acc_r, acc_nxt;

  logic [RAM_AW-1:0]  red;
  logic [VRAM_AW-1:0] vidx;
  logic [1:0]         st;
  logic [3:0]         cmd;

  // bank-relative address folded back into the bank
  assign red  = (ram_r >= RAM_AW'(BANK_BYTES)) ? (ram_r - RAM_AW'(BANK_BYTES)) : ram_r;
  assign vidx = bank_r ? (VRAM_AW'(red) + VRAM_AW'(BANK_BYTES)) : VRAM_AW'(red);
  assign rd_addr_o = vidx;

  always_comb begin
    ctl_nxt  = ctl_r;
    pidx_nxt = pidx_r;
    pb0_nxt  = pb0_r;
    bank_nxt = bank_r;
    ram_nxt  = ram_r;
    tc_nxt   = tc_r;
    st       = pidx_r;
    cmd      = pb0_r[3:0];
    acc_nxt.valid = valid_i;
    acc_nxt.act   = BUS_KEEP;
    acc_nxt.wr    = 1'b0;
    acc_nxt.rop   = pb0_r[7:5];
    acc_nxt.data  = data_i;
    acc_nxt.addr  = vidx;
    case (op_i)
      OP_CTRL: begin
        if (ctl_r == data_i) begin
          pidx_nxt = 2'd0;
        end
        ctl_nxt = data_i;
      end
      OP_WRITE: begin
        if (ctl_r[7] && ctl_r[0]) begin
          if (ctl_r[1] || ctl_r[2]) begin
            if (pidx_r != PIDX_LAST) begin
              if (pidx_r == 2'd0) begin
                pb0_nxt = data_i;
              end
              st = pidx_r + 2'd1;
            end
            pidx_nxt = st;
            cmd      = pb0_nxt[3:0];
            case (cmd)
              CMD_VREAD, CMD_VWRITE, CMD_CHAR: begin
                if (st == 2'd1) begin
                  bank_nxt = data_i[4];
                end else if (st == 2'd2) begin
                  ram_nxt = column_code(data_i);
                end else if (st == 2'd3) begin
                  ram_nxt = ram_r + (RAM_AW'(data_i[1:0]) * RAM_AW'(96));
                end
              end
              CMD_DISP, CMD_MODE, CMD_CURMODE, CMD_IRQ: begin
                pidx_nxt = 2'd0;
              end
              CMD_CONTRAST, CMD_CURPOS: begin
                if (st == 2'd3) begin
                  pidx_nxt = 2'd0;
                end
              end
              default: begin
              end
            endcase
            tc_nxt      = 8'd0;
            acc_nxt.act = BUS_ONES;
          end
        end else if (ctl_r[7]) begin
          case (pb0_r[3:0])
            CMD_VREAD: begin
              if (pb0_r[7:5] == ROP_ANDN) begin
                acc_nxt.act = BUS_SWAP;
                ram_nxt     = red + RAM_AW'(1);
                tc_nxt      = tc_r + 8'd1;
              end
            end
            CMD_VWRITE: begin
              acc_nxt.wr  = 1'b1;
              acc_nxt.act = BUS_ONES;
              ram_nxt     = red + RAM_AW'(1);
              tc_nxt      = tc_r + 8'd1;
            end
            CMD_CHAR: begin
              acc_nxt.act = BUS_ONES;
              tc_nxt      = tc_r + 8'd1;
            end
            CMD_CURPAT, CMD_GLYPH: begin
              if (tc_r < 8'd8) begin
                acc_nxt.act = BUS_ONES;
                tc_nxt      = tc_r + 8'd1;
              end
            end
            CMD_CURCHR: begin
              if (tc_r == 8'd0) begin
                acc_nxt.act = BUS_ONES;
                tc_nxt      = tc_r + 8'd1;
              end
            end
            default: begin
              acc_nxt.act = BUS_ONES;
            end
          endcase
          pidx_nxt = 2'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= 8'd0;
      pidx_r <= 2'd0;
      pb0_r  <= 8'd0;
      bank_r <= 1'b0;
      ram_r  <= '0;
      tc_r   <= 8'd0;
      acc_r  <= '0;
    end else if (adv_i) begin
      acc_r <= acc_nxt;
      if (valid_i) begin
        ctl_r  <= ctl_nxt;
        pidx_r <= pidx_nxt;
        pb0_r  <= pb0_nxt;
        bank_r <= bank_nxt;
        ram_r  <= ram_nxt;
        tc_r   <= tc_nxt;
      end
    end
  end

  assign acc_o = acc_r;

endmodule

/* rtl/core/lcdv_vram.sv */
module lcdv_vram
  import lcdv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv_i,
  input  lcdv_acc_t          acc_i,
  input  logic [VRAM_AW-1:0] rd_addr_i,
  output logic               clr_busy_o,
  output logic               out_valid_o,
  output logic [7:0]         out_read_data_o
);

  logic [7:0] mem [VRAM_DEPTH];

  logic               clr_busy_r;
  logic [VRAM_AW-1:0] clr_cnt_r;
  logic [7:0]         rdata_r;
  logic               fwd_r;
  logic [7:0]         fwd_data_r;
  logic [7:0]         bus_latch_r, bus_latch_nxt;
  logic               out_valid_r;
  logic [7:0]         out_data_r;

  logic [7:0]         old_val;
  logic [7:0]         wval;
  logic               wr_en;
  logic [VRAM_AW-1:0] wr_addr;
  logic [7:0]         wr_data;

  assign old_val = fwd_r ? fwd_data_r : rdata_r;
  assign wval    = raster_op(acc_i.rop, old_val, acc_i.data);

  always_comb begin
    case (acc_i.act)
      BUS_ONES: bus_latch_nxt = 8'hff;
      BUS_SWAP: bus_latch_nxt = {old_val[3:0], old_val[7:4]};
      default:  bus_latch_nxt = bus_latch_r;
    endcase
  end

  // clearing pass has the write port while it runs
  assign wr_en   = clr_busy_r || (adv_i && acc_i.valid && acc_i.wr);
  assign wr_addr = clr_busy_r ? clr_cnt_r : acc_i.addr;
  assign wr_data = clr_busy_r ? 8'h00 : wval;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      rdata_r <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == VRAM_AW'(VRAM_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + VRAM_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r       <= 1'b0;
      bus_latch_r <= 8'hff;
      out_valid_r <= 1'b0;
    end else if (adv_i) begin
      fwd_r       <= acc_i.valid && acc_i.wr && (acc_i.addr == rd_addr_i);
      out_valid_r <= acc_i.valid;
      if (acc_i.valid) begin
        bus_latch_r <= bus_latch_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      fwd_data_r <= wval;
      if (acc_i.valid) begin
        out_data_r <= bus_latch_nxt;
      end
    end
  end

  assign clr_busy_o      = clr_busy_r;
  assign out_valid_o     = out_valid_r;
  assign out_read_data_o = out_data_r;

`ifndef SYNTHESIS
  a_no_beat_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !acc_i.valid)
    else $error("access reached video ram during clearing pass");

  a_clr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (clr_cnt_r < VRAM_AW'(VRAM_DEPTH)))
    else $error("clear counter out of range");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    adv_i |=> (fwd_r == $past(acc_i.valid && acc_i.wr && (acc_i.addr == rd_addr_i))))
    else $error("bypass flag does not match the previous write");

  a_ones_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_i && acc_i.valid && acc_i.act == BUS_ONES) |=>
      (out_valid_r && out_data_r == 8'hff))
    else $error("bus latch not set to ones");
`endif

endmodule

/* rtl/core/lcd_command_and_vram_port_top.sv */
// a beat is registered at the input, in the command stage, then at the output
// throughput: one beat per cycle unless stalled; single video ram port pair
// reset: synchronous active low; afterwards a clearing pass zeroes the
// 768-byte video ram, one byte a cycle, holding in_stall high while it runs
module lcd_command_and_vram_port_top
  import lcdv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data
);

  logic               adv;
  logic               clr_busy;
  logic               in_valid_r;
  logic [1:0]         in_op_r;
  logic [7:0]         in_data_r;
  logic [VRAM_AW-1:0] rd_addr;
  lcdv_acc_t          acc;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = clr_busy || !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (adv) begin
      in_valid_r <= in_valid && !clr_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op_r   <= in_op;
      in_data_r <= in_data;
    end
  end

  lcdv_cmd u_cmd (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv_i     (adv),
    .valid_i   (in_valid_r),
    .op_i      (in_op_r),
    .data_i    (in_data_r),
    .rd_addr_o (rd_addr),
    .acc_o     (acc)
  );

  lcdv_vram u_vram (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv_i           (adv),
    .acc_i           (acc),
    .rd_addr_i       (rd_addr),
    .clr_busy_o      (clr_busy),
    .out_valid_o     (out_valid),
    .out_read_data_o (out_read_data)
  );

endmodule
